// ----- src/isws_pkg.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared sizes, the command passed from front to back, and the result item.
// ----------------------------------------------------------------------------
package isws_pkg;

  // Store depth and width of one stored value.
  localparam int DEPTH       = 32;
  localparam int VALUE_WIDTH = 32;

  // Fill count holds 0 through DEPTH.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the stream ports.
  localparam int IN_W   = 32;
  localparam int ELEM_W = 32;
  localparam int SC_W   = 6;

  // Command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Result kinds carried in tuser bit 0.
  localparam logic KIND_SHIFT  = 1'b0;
  localparam logic KIND_SORTED = 1'b1;

  // One classified input item.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    logic                   ovf;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] element;
    logic [SC_W-1:0]   shift_count;
    logic              overflow;
    logic              end_of_run;
  } result_t;

endpackage

// ----- src/isws_front.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter front end
// Accepts input transfers, tracks the projected fill level and marks values
// that will find the store full.
// ----------------------------------------------------------------------------
module isws_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [isws_pkg::IN_W-1:0]  in_value,
  input  logic                       in_last,
  output logic                       q_push,
  output isws_pkg::cmd_t             q_cmd,
  input  logic                       q_full
);

  // Fill level the store will have once every queued command is done.
  logic [isws_pkg::CNT_W-1:0] fill;
  logic                       full_now;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign full_now = (fill == isws_pkg::CNT_W'(isws_pkg::DEPTH));

  // Classify the incoming value.
  always_comb begin
    q_cmd.value = isws_pkg::VALUE_WIDTH'($unsigned(in_value));
    q_cmd.last  = in_last;
    q_cmd.ovf   = full_now;
  end

  // A final item empties the store; otherwise a stored value adds one.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (q_push) begin
      if (in_last) begin
        fill <= '0;
      end else if (!full_now) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

// ----- src/isws_queue.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter command queue
// Small register queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module isws_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  isws_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output isws_pkg::cmd_t head_cmd,
  input  logic           pop
);

  isws_pkg::cmd_t        slots [isws_pkg::Q_DEPTH];
  logic [isws_pkg::Q_AW:0] wr_ptr;
  logic [isws_pkg::Q_AW:0] rd_ptr;

  // Pointers carry one extra bit to tell full from empty.
  assign head_valid = (wr_ptr != rd_ptr);
  assign full = (wr_ptr[isws_pkg::Q_AW] != rd_ptr[isws_pkg::Q_AW]) &&
                (wr_ptr[isws_pkg::Q_AW-1:0] == rd_ptr[isws_pkg::Q_AW-1:0]);
  assign head_cmd = slots[rd_ptr[isws_pkg::Q_AW-1:0]];

  // Pointer update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Slot write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[isws_pkg::Q_AW-1:0]] <= push_cmd;
    end
  end

endmodule

// ----- src/isws_back.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter back end
// Row of compare cells holding the sorted values, a step sequencer that
// inserts one command at a time, and the result output register.
// ----------------------------------------------------------------------------
module isws_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  isws_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output isws_pkg::result_t res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_POS   = 5'b00100,
    S_INS   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t                            state;
  isws_pkg::cmd_t                    cmd;
  logic [isws_pkg::VALUE_WIDTH-1:0]  cells [isws_pkg::DEPTH];
  logic [isws_pkg::CNT_W-1:0]        fill;
  logic [isws_pkg::DEPTH-1:0]        greater;
  logic [isws_pkg::DEPTH-1:0]        greater_c;
  logic [isws_pkg::DEPTH-1:0]        ins_c;
  logic [isws_pkg::CNT_W-1:0]        pos;
  logic [isws_pkg::CNT_W-1:0]        pos_c;
  logic                              load_ok;
  logic                              res_load;

  // The output register can take a new result when empty or being drained.
  assign load_ok  = !res_valid || res_ready;
  assign res_load = load_ok && ((state == S_INS) || (state == S_DRAIN));
  assign q_pop    = (state == S_IDLE) && q_valid;

  // Each valid cell compares its value with the incoming one.
  always_comb begin
    for (int i = 0; i < isws_pkg::DEPTH; i++) begin
      greater_c[i] = (isws_pkg::CNT_W'(i) < fill) &&
                     ($signed(cells[i]) > $signed(cmd.value));
    end
  end

  // Insert position: first cell that is greater or not yet filled.
  always_comb begin
    pos_c = fill;
    for (int i = isws_pkg::DEPTH - 1; i >= 0; i--) begin
      if (greater[i]) begin
        pos_c = isws_pkg::CNT_W'(i);
      end
    end
  end

  // Cells at or above the insert position take part in the shift.
  always_comb begin
    for (int i = 0; i < isws_pkg::DEPTH; i++) begin
      ins_c[i] = (isws_pkg::CNT_W'(i) >= pos);
    end
  end

  // Sequencer, cell row and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          greater <= greater_c;
          state   <= S_POS;
        end
        S_POS: begin
          pos   <= pos_c;
          state <= S_INS;
        end
        S_INS: begin
          if (load_ok) begin
            res_valid       <= 1'b1;
            res.kind        <= isws_pkg::KIND_SHIFT;
            res.element     <= '0;
            res.end_of_run  <= 1'b0;
            res.overflow    <= cmd.ovf;
            if (cmd.ovf) begin
              res.shift_count <= '0;
            end else begin
              res.shift_count <= isws_pkg::SC_W'(fill - pos);
              fill            <= fill + 1'b1;
              if (ins_c[0]) begin
                cells[0] <= cmd.value;
              end
              for (int i = 1; i < isws_pkg::DEPTH; i++) begin
                if (ins_c[i]) begin
                  cells[i] <= ins_c[i-1] ? cells[i-1] : cmd.value;
                end
              end
            end
            state <= cmd.last ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          if (load_ok) begin
            res_valid       <= 1'b1;
            res.kind        <= isws_pkg::KIND_SORTED;
            res.element     <= isws_pkg::ELEM_W'($unsigned(cells[0]));
            res.shift_count <= '0;
            res.overflow    <= 1'b0;
            res.end_of_run  <= (fill == isws_pkg::CNT_W'(1));
            fill            <= fill - 1'b1;
            for (int i = 0; i < isws_pkg::DEPTH - 1; i++) begin
              cells[i] <= cells[i+1];
            end
            if (fill == isws_pkg::CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/insertion_sorter_with_shift_count_top.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter with shift count
// Sorts a run of signed values and reports how far each one moved.
// ----------------------------------------------------------------------------
// Each accepted value yields one shift count transfer giving the number of
// stored values strictly greater than it, or an overflow flag when the
// 32-entry store is full. A value with tlast set is followed by the stored
// values in ascending order, the last marked with tlast, and the store is
// then empty. A value passes through the insertion sequencer steps (compare
// across the cell row, position encode, shift insert with result load), and
// a final value then adds the sorted read-out of every stored value. A
// four-entry command queue lets input transfers continue while the back end
// waits on the output. No clearing pass follows reset.
module insertion_sorter_with_shift_count_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // final_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] element, [37:32] shift_count, rest zero
  output logic [1:0]  m_tuser,   // [0] kind, [1] overflow
  output logic        m_tlast    // end_of_run
);

  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  isws_pkg::cmd_t    push_cmd;
  isws_pkg::cmd_t    head_cmd;
  isws_pkg::result_t res;

  isws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata),
    .in_last  (s_tlast),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_full   (q_full)
  );

  isws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  isws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result onto the output stream.
  assign m_tdata = {2'b00, res.shift_count, res.element};
  assign m_tuser = {res.overflow, res.kind};
  assign m_tlast = res.end_of_run;

  // A sorted element carries no shift count and no overflow.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[37:32] == '0 && !m_tuser[1]))
    else $error("sorted element with shift count or overflow");

  // A shift count report never ends a run and carries no element.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (!m_tlast && m_tdata[31:0] == '0))
    else $error("shift count report with end of run or element");

  // A dropped value reports no shift.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[37:32] == '0))
    else $error("overflow report with nonzero shift count");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Insertion sorter with shift count testbench
// Streams signed values into the sorter, keeps its own sorted store to predict
// each shift count, overflow flag and sorted read-out, and compares every
// output transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;

  // Clock and reset.
  logic clk;
  logic rst;

  // Input stream.
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic        s_tlast;   // final_item

  // Output stream.
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] element, [37:32] shift_count, rest zero
  logic [1:0]  m_tuser;   // [0] kind, [1] overflow
  logic        m_tlast;   // end_of_run

  // Extra cycles allowed after the last result for anything stray to show up.
  localparam int SETTLE_CYCLES = 40;

  insertion_sorter_with_shift_count_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Predicted sorter state and the results still to arrive.
  logic signed [isws_pkg::VALUE_WIDTH-1:0] sorted_copy [isws_pkg::DEPTH];
  int                held_count = 0;
  isws_pkg::result_t pending_results [$];

  // Run statistics.
  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  runs_sent       = 0;
  int  overflow_items  = 0;
  bit  calm            = 1'b0;

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall limit on the run.
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

  // Insert one value into the predicted store and queue the results it causes.
  task automatic sort_and_report(input logic [31:0] value, input logic last);
    logic signed [isws_pkg::VALUE_WIDTH-1:0] v;
    isws_pkg::result_t r;
    int pos;
    v = value;
    if (held_count < isws_pkg::DEPTH) begin
      // The new value lands after every held value that is not greater.
      pos = 0;
      while (pos < held_count && sorted_copy[pos] <= v) pos++;
      for (int i = held_count; i > pos; i--) sorted_copy[i] = sorted_copy[i-1];
      sorted_copy[pos] = v;
      r = '0;
      r.kind        = isws_pkg::KIND_SHIFT;
      r.shift_count = isws_pkg::SC_W'(held_count - pos);
      pending_results.push_back(r);
      held_count++;
    end else begin
      // Store full: the value is dropped.
      r = '0;
      r.kind     = isws_pkg::KIND_SHIFT;
      r.overflow = 1'b1;
      pending_results.push_back(r);
      overflow_items++;
    end
    if (last) begin
      // Read-out of the whole store, then it is empty again.
      for (int i = 0; i < held_count; i++) begin
        r = '0;
        r.kind       = isws_pkg::KIND_SORTED;
        r.element    = sorted_copy[i];
        r.end_of_run = (i == held_count - 1);
        pending_results.push_back(r);
      end
      held_count = 0;
      runs_sent++;
    end
  endtask

  // Send one value, with a random gap first unless the run is in its calm part.
  task automatic send_value(input logic [31:0] value, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sort_and_report(value, last);
    items_sent++;
  endtask

  // Hold the input off until every predicted result has been seen.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random value biased toward the extremes and toward small repeated values.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2, 3:    v = $urandom_range(0, 8) - 32'd4;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Extremes, equal values, a one-value run and a run ending in descending values.
  task automatic test_extremes();
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h5a5a_5a5a, 1'b1);
    send_value(32'h5555_5555, 1'b0);
    send_value(32'haaaa_aaaa, 1'b0);
    send_value(32'h0000_0004, 1'b0);
    send_value(32'h0000_0003, 1'b0);
    send_value(32'h0000_0002, 1'b0);
    send_value(32'h0000_0001, 1'b1);
  endtask

  // Fill the store with descending values, then overflow it, the final item
  // being one that is dropped.
  task automatic test_full_store();
    logic [31:0] cur;
    cur = 32'd100_000_000 + $urandom_range(0, 1_000_000);
    for (int i = 0; i < isws_pkg::DEPTH; i++) begin
      send_value(cur, 1'b0);
      cur = cur - $urandom_range(1, 50_000);
    end
    send_value(pick_value(), 1'b0);
    send_value(pick_value(), 1'b1);
    wait_for_drain();
  endtask

  // Runs of random length, mostly short, a few long enough to fill the store.
  task automatic test_random_runs(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++) send_value(pick_value(), j == len - 1);
      sent += len;
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_back_to_back(input int count);
    int sent;
    int len;
    calm = 1'b1;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 10);
      for (int j = 0; j < len; j++) send_value(pick_value(), j == len - 1);
      sent += len;
    end
  endtask

  // Output side: ready drops in random bursts outside the calm part.
  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest predicted result.
  always @(posedge clk) begin
    isws_pkg::result_t got;
    isws_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind        = m_tuser[0];
      got.overflow    = m_tuser[1];
      got.element     = m_tdata[isws_pkg::ELEM_W-1:0];
      got.shift_count = m_tdata[isws_pkg::ELEM_W+isws_pkg::SC_W-1:isws_pkg::ELEM_W];
      got.end_of_run  = m_tlast;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected kind=%0b elem=%08h shift=%0d ovf=%0b last=%0b",
                   $realtime, got.kind, got.element, got.shift_count,
                   got.overflow, got.end_of_run);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.element != want.element ||
            got.shift_count != want.shift_count || got.overflow != want.overflow ||
            got.end_of_run != want.end_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected kind=%0b elem=%08h shift=%0d ovf=%0b last=%0b",
                     $realtime, want.kind, want.element, want.shift_count,
                     want.overflow, want.end_of_run);
            $display("%0t:      got kind=%0b elem=%08h shift=%0d ovf=%0b last=%0b",
                     $realtime, got.kind, got.element, got.shift_count,
                     got.overflow, got.end_of_run);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_full_store();
    test_random_runs(85);
    test_back_to_back(25);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d values in %0d runs, %0d of them dropped on a full store",
             items_sent, runs_sent, overflow_items);
    $display("checked %0d output transfers, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/isws_pkg.sv
src/isws_front.sv
src/isws_queue.sv
src/isws_back.sv
src/insertion_sorter_with_shift_count_top.sv
sim/tb.sv
